// ----- rtl/linear_key_value_table_defines.svh -----
// Assertion macros for the linear key/value table.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef LINEAR_KEY_VALUE_TABLE_DEFINES_SVH
`define LINEAR_KEY_VALUE_TABLE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define LKV_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled in reset.
`define LKV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/lkv_pkg.sv -----
// Shared sizes, request and status codes and the RAM request struct
// for the linear key/value table. No dependencies.
package lkv_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int KEY_BITS    = 32;
	localparam int VALUE_BITS  = 32;
	localparam int ENTRY_BITS  = KEY_BITS + VALUE_BITS;
	localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
	localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [2:0] {
		REQ_ACCESS = 3'd0,
		REQ_WRITE  = 3'd1,
		REQ_PEEK   = 3'd2,
		REQ_ERASE  = 3'd3,
		REQ_CLEAR  = 3'd4
	} req_t;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ABSENT = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	// One entry word is {key, value}
	typedef struct packed {
		logic                  we;
		logic [IDX_BITS-1:0]   waddr;
		logic [ENTRY_BITS-1:0] wdata;
		logic                  re;
		logic [IDX_BITS-1:0]   raddr;
	} mem_req_t;

endpackage

// ----- rtl/lkv_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module lkv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/lkv_ctrl.sv -----
// Request sequencer: linear scan, update, erase swap-with-last, count.
// Depends on lkv_pkg; drives the entry RAM through a mem_req_t.
module lkv_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [2:0]                    req_type,
	input  logic [31:0]                   key,
	input  logic [31:0]                   wr_value,
	output logic                          busy,
	output logic                          done,
	output logic [31:0]                   value,
	output logic                          hit,
	output logic [1:0]                    status,
	output logic [4:0]                    entry_count,
	output lkv_pkg::mem_req_t             mem_req,
	input  logic [lkv_pkg::ENTRY_BITS-1:0] rd_data
);
	import lkv_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_ERD, S_EWR} state_t;

	state_t                state_q;
	req_t                  req_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] wv_q;
	logic [CNT_BITS-1:0]   count_q;
	logic [CNT_BITS-1:0]   scan_q;
	logic [IDX_BITS-1:0]   pos_q;
	logic                  chk_s1;
	logic [IDX_BITS-1:0]   chkidx_s1;
	logic                  done_q;
	logic [VALUE_BITS-1:0] value_q;
	logic                  hit_q;
	logic [1:0]            status_q;

	logic [KEY_BITS-1:0]   entry_key;
	logic [VALUE_BITS-1:0] entry_val;
	logic [CNT_BITS-1:0]   cnt_m1;
	logic                  is_last;
	logic                  has_room;
	logic                  scan_hit;
	logic                  scan_miss;
	logic                  is_insert;
	req_t                  in_req;

	assign in_req    = req_t'(req_type);
	assign entry_key = rd_data[ENTRY_BITS-1 -: KEY_BITS];
	assign entry_val = rd_data[VALUE_BITS-1:0];
	assign cnt_m1    = count_q - CNT_BITS'(1);
	assign is_last   = ({1'b0, chkidx_s1} == (IDX_BITS + 1)'(cnt_m1));
	assign has_room  = (count_q < CNT_BITS'(TABLE_DEPTH));
	assign is_insert = (req_q == REQ_ACCESS) || (req_q == REQ_WRITE);
	assign scan_hit  = (state_q == S_SCAN) && chk_s1 && (entry_key == key_q);
	// Empty table: nothing to read, decide at once
	assign scan_miss = (state_q == S_SCAN) &&
		((chk_s1 && (entry_key != key_q) && is_last) ||
		 (!chk_s1 && (count_q == '0)));

	always_comb begin
		mem_req = '0;
		case (state_q)
			S_SCAN: begin
				mem_req.re    = (scan_q < count_q);
				mem_req.raddr = scan_q[IDX_BITS-1:0];
				if (scan_hit && (req_q == REQ_WRITE)) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = chkidx_s1;
					mem_req.wdata = {key_q, wv_q};
				end else if (scan_miss && is_insert && has_room) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = count_q[IDX_BITS-1:0];
					mem_req.wdata = {key_q, (req_q == REQ_WRITE) ? wv_q : VALUE_BITS'(0)};
				end
			end
			S_ERD: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = cnt_m1[IDX_BITS-1:0];
			end
			S_EWR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = pos_q;
				mem_req.wdata = rd_data;
			end
			default: begin
				mem_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			chk_s1  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q    <= in_req;
						key_q    <= key[KEY_BITS-1:0];
						wv_q     <= wr_value[VALUE_BITS-1:0];
						scan_q   <= '0;
						chk_s1   <= 1'b0;
						value_q  <= '0;
						hit_q    <= 1'b0;
						status_q <= ST_OK;
						case (in_req)
							REQ_ACCESS, REQ_WRITE, REQ_PEEK, REQ_ERASE: begin
								state_q <= S_SCAN;
							end
							REQ_CLEAR: begin
								count_q <= '0;
								done_q  <= 1'b1;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_SCAN: begin
					chk_s1    <= mem_req.re;
					chkidx_s1 <= scan_q[IDX_BITS-1:0];
					if (mem_req.re) begin
						scan_q <= scan_q + CNT_BITS'(1);
					end
					if (scan_hit) begin
						hit_q   <= 1'b1;
						value_q <= (req_q == REQ_WRITE) ? wv_q : entry_val;
						pos_q   <= chkidx_s1;
						chk_s1  <= 1'b0;
						if ((req_q == REQ_ERASE) && !is_last) begin
							state_q <= S_ERD;
						end else begin
							if (req_q == REQ_ERASE) begin
								count_q <= cnt_m1;
							end
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end else if (scan_miss) begin
						chk_s1  <= 1'b0;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
						if (is_insert) begin
							if (has_room) begin
								count_q <= count_q + CNT_BITS'(1);
								value_q <= (req_q == REQ_WRITE) ? wv_q : VALUE_BITS'(0);
							end else begin
								status_q <= ST_FULL;
							end
						end else if (req_q == REQ_ERASE) begin
							status_q <= ST_ABSENT;
						end
					end
				end
				S_ERD: begin
					state_q <= S_EWR;
				end
				S_EWR: begin
					count_q <= cnt_m1;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign value       = 32'(value_q);
	assign hit         = hit_q;
	assign status      = status_q;
	assign entry_count = 5'(count_q);

endmodule

// ----- rtl/linear_key_value_table.sv -----
// Top level of the linear key/value table: sequencer plus entry RAM.
// Depends on lkv_pkg, lkv_ram, lkv_ctrl and linear_key_value_table_defines.svh.

// A small unsorted table of up to TABLE_DEPTH key/value pairs. A request
// word is taken at the clock edge where start is high and busy is low; its
// single result word appears on value/hit/status/entry_count for exactly one
// cycle with done high, and must be taken then - there is no back-pressure.
// Requests run one at a time. Keys and values sit together in one RAM with
// a registered read, and lookup scans the used entries one per cycle through
// that read port. A hit ends the scan at the matching slot, a miss ends it
// after the last used entry (at once for an empty table), an erase that must
// move the last entry into the freed slot then reads it and writes it there,
// and clear or an unused code answers straight from idle. The entry count is
// held in a flip-flop and reset to zero; RAM contents are never cleared, only
// entries below the count are read. Every RAM write finishes before the next
// request's first read, so no forwarding is needed. A full table refuses
// inserts with status full.
module linear_key_value_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  req_type,
	input  logic [31:0] key,
	input  logic [31:0] wr_value,
	output logic        done,
	output logic [31:0] value,
	output logic        hit,
	output logic [1:0]  status,
	output logic [4:0]  entry_count
);
	import lkv_pkg::*;

	`include "linear_key_value_table_defines.svh"

	mem_req_t              mem_req;
	logic [ENTRY_BITS-1:0] rd_data;

	// Scan, update and swap-with-last sequencing
	lkv_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.req_type    (req_type),
		.key         (key),
		.wr_value    (wr_value),
		.busy        (busy),
		.done        (done),
		.value       (value),
		.hit         (hit),
		.status      (status),
		.entry_count (entry_count),
		.mem_req     (mem_req),
		.rd_data     (rd_data)
	);

	// Entry store: {key, value} per word
	lkv_ram #(
		.WIDTH (ENTRY_BITS),
		.DEPTH (TABLE_DEPTH)
	) u_entries (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (rd_data)
	);

	// An accepted word either starts work or answers on the next cycle
	`LKV_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done, "accepted word stalled")
	// Count never passes the table size
	`LKV_ASSERT_NOW(a_count_bound, done, entry_count <= 5'(TABLE_DEPTH), "entry count overflow")
	// Full refusal only with a full table and no hit
	`LKV_ASSERT_NOW(a_full_consistent, done && (status == ST_FULL),
		(entry_count == 5'(TABLE_DEPTH)) && !hit, "bad full report")
	// A hit is always a success
	`LKV_ASSERT_NOW(a_hit_ok, done && hit, status == ST_OK, "hit with error status")

endmodule
